// ===== src/alw_pkg.sv =====
`default_nettype none

package alw_pkg;

   // fixed field geometry
   localparam int FIELD_CHARS = 3;
   localparam int FIELD_W     = 8 * FIELD_CHARS;
   localparam int NUM_W       = 17;
   localparam int MAX_A       = 32767;

   // error codes
   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_COMP = 3'd1;
   localparam logic [2:0] ERR_JUMP = 3'd2;
   localparam logic [2:0] ERR_NUM  = 3'd3;
   localparam logic [2:0] ERR_LONG = 3'd4;

   typedef struct packed {
      logic [2:0]         dest_bits;
      logic [FIELD_W-1:0] comp_text;
      logic               comp_seen;
      logic [FIELD_W-1:0] field_buffer;
      logic [2:0]         pending_error;
   } c_fields_type;

   typedef struct packed {
      logic [15:0] machine_word;
      logic [2:0]  error_code;
   } c_result_type;

   typedef struct packed {
      logic       hit;
      logic [6:0] code;
   } comp_match_type;

   // comp mnemonic (packed, first char highest) to its a and c1..c6 bits
   function automatic comp_match_type comp_lookup(input logic [FIELD_W-1:0] text);
      comp_match_type m;
      m.hit = 1'b1;
      unique case (text)
         24'h000030: m.code = 7'h2A; // 0
         24'h000031: m.code = 7'h3F; // 1
         24'h002D31: m.code = 7'h3A; // -1
         24'h000044: m.code = 7'h0C; // D
         24'h000041: m.code = 7'h30; // A
         24'h002144: m.code = 7'h0D; // !D
         24'h002141: m.code = 7'h31; // !A
         24'h002D44: m.code = 7'h0F; // -D
         24'h002D41: m.code = 7'h33; // -A
         24'h442B31: m.code = 7'h1F; // D+1
         24'h412B31: m.code = 7'h37; // A+1
         24'h442D31: m.code = 7'h0E; // D-1
         24'h412D31: m.code = 7'h32; // A-1
         24'h442B41: m.code = 7'h02; // D+A
         24'h442D41: m.code = 7'h13; // D-A
         24'h412D44: m.code = 7'h07; // A-D
         24'h442641: m.code = 7'h00; // D&A
         24'h447C41: m.code = 7'h15; // D|A
         24'h00004D: m.code = 7'h70; // M
         24'h00214D: m.code = 7'h71; // !M
         24'h002D4D: m.code = 7'h73; // -M
         24'h4D2B31: m.code = 7'h77; // M+1
         24'h4D2D31: m.code = 7'h72; // M-1
         24'h442B4D: m.code = 7'h42; // D+M
         24'h442D4D: m.code = 7'h53; // D-M
         24'h4D2D44: m.code = 7'h47; // M-D
         24'h44264D: m.code = 7'h40; // D&M
         24'h447C4D: m.code = 7'h55; // D|M
         default: begin
            m.hit  = 1'b0;
            m.code = 7'h00;
         end
      endcase
      return m;
   endfunction

   // jump mnemonic to j1..j3, zero when unknown
   function automatic logic [2:0] jump_lookup(input logic [FIELD_W-1:0] text);
      logic [2:0] j;
      unique case (text)
         24'h4A4754: j = 3'd1; // JGT
         24'h4A4551: j = 3'd2; // JEQ
         24'h4A4745: j = 3'd3; // JGE
         24'h4A4C54: j = 3'd4; // JLT
         24'h4A4E45: j = 3'd5; // JNE
         24'h4A4C45: j = 3'd6; // JLE
         24'h4A4D50: j = 3'd7; // JMP
         default:    j = 3'd0;
      endcase
      return j;
   endfunction

endpackage

`default_nettype wire

// ===== src/alw_c_encoder.sv =====
`default_nettype none

module alw_c_encoder (
   input  wire alw_pkg::c_fields_type fields,
   output alw_pkg::c_result_type result
);
   import alw_pkg::*;

   logic [FIELD_W-1:0] comp_sel;
   comp_match_type     comp_m;
   logic [2:0]         jump_code;
   logic               jump_ok;
   logic [2:0]         err;

   // without a ';' the open field is the comp and there is no jump
   assign comp_sel  = fields.comp_seen ? fields.comp_text : fields.field_buffer;
   assign comp_m    = comp_lookup(comp_sel);
   assign jump_code = fields.comp_seen ? jump_lookup(fields.field_buffer) : 3'd0;
   assign jump_ok   = !fields.comp_seen || (jump_code != 3'd0);

   always_comb begin
      err = fields.pending_error;
      if (err == ERR_NONE && !comp_m.hit) err = ERR_COMP;
      if (err == ERR_NONE && !jump_ok)    err = ERR_JUMP;
   end

   assign result.error_code   = err;
   assign result.machine_word = (err != ERR_NONE) ? 16'h0000
                              : {3'b111, comp_m.code, fields.dest_bits, jump_code};

endmodule

`default_nettype wire

// ===== src/asm_line_to_machine_word_core.sv =====
`default_nettype none

// latency: the request that ends a line writes its result into the rsp register, valid the cycle after
// throughput: one character request per cycle; parse state and table compares are combinational
// a result waiting in the rsp register stalls every further request until it is taken
// reset (synchronous, active high): parser idle, fields cleared, line counter at 1,
// result register empty
module asm_line_to_machine_word_core #(
   parameter int NUMBER_DIGITS = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_in,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_machine_word,
   output logic [2:0]       rsp_error_code,
   output logic [15:0]      rsp_line_number
);
   import alw_pkg::*;

   localparam int DIGIT_W = $clog2(NUMBER_DIGITS + 1);

   // parser state codes
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_SKIP  = 3'd1;
   localparam logic [2:0] MODE_LABEL = 3'd2;
   localparam logic [2:0] MODE_ANUM  = 3'd3;
   localparam logic [2:0] MODE_CINST = 3'd4;

   // characters the parser looks at
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_A      = 8'h41;
   localparam logic [7:0] CH_D      = 8'h44;
   localparam logic [7:0] CH_M      = 8'h4D;

   // parse state
   logic [2:0]         mode_ff, mode_in;
   logic [FIELD_W-1:0] field_buffer_ff, field_buffer_in;
   logic [1:0]         field_length_ff, field_length_in;
   logic [2:0]         dest_bits_ff, dest_bits_in;
   logic [FIELD_W-1:0] comp_text_ff, comp_text_in;
   logic               comp_seen_ff, comp_seen_in;
   logic [NUM_W-1:0]   number_value_ff, number_value_in;
   logic [DIGIT_W-1:0] digit_count_ff, digit_count_in;
   logic [2:0]         pending_error_ff, pending_error_in;
   logic [15:0]        line_counter_ff, line_counter_in;

   // result register
   logic               rsp_valid_ff;
   logic [15:0]        rsp_word_ff;
   logic [2:0]         rsp_error_ff;
   logic [15:0]        rsp_line_ff;

   logic               accept;
   logic               line_end;
   logic               space;
   logic               digit;
   logic [3:0]         digit_val;
   logic [NUM_W+2:0]   num_next_wide;
   logic               cinst;
   logic               emit;
   logic [15:0]        emit_word;
   logic [2:0]         emit_error;
   logic [2:0]         a_error;
   c_fields_type       c_fields;
   c_result_type       c_result;

   // dest bits from the A, D and M characters held in a field
   function automatic logic [2:0] dest_from(input logic [FIELD_W-1:0] buf_v);
      logic [2:0] d;
      d = 3'b000;
      for (int i = 0; i < FIELD_CHARS; i++) begin
         if (buf_v[8*i +: 8] == CH_A) d[2] = 1'b1;
         if (buf_v[8*i +: 8] == CH_D) d[1] = 1'b1;
         if (buf_v[8*i +: 8] == CH_M) d[0] = 1'b1;
      end
      return d;
   endfunction

   // a new request is taken while the result register is empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // character classes; end of input hides the character and acts as a line end
   assign line_end = req_end_of_input || (req_char_in == CH_NL);
   assign space    = !req_end_of_input &&
                     ((req_char_in == CH_SPACE) || (req_char_in == CH_NUL) ||
                      ((req_char_in >= CH_TAB) && (req_char_in <= CH_CR)));
   assign digit    = !req_end_of_input &&
                     (req_char_in >= CH_ZERO) && (req_char_in <= CH_NINE);
   assign digit_val = 4'(req_char_in - CH_ZERO);

   // value * 10 + digit, kept to the number register width
   assign num_next_wide = {number_value_ff, 3'b000} + {2'b00, number_value_ff, 1'b0}
                        + {{(NUM_W-1){1'b0}}, digit_val};

   // numeric A-instruction error: missing digits or value beyond 15 bits, else the pending error
   assign a_error = ((digit_count_ff == '0) || (number_value_ff > NUM_W'(MAX_A)))
                  ? ERR_NUM : pending_error_ff;

   // a C-instruction finishes only from registered fields, never on the starting character
   assign c_fields.dest_bits     = dest_bits_ff;
   assign c_fields.comp_text     = comp_text_ff;
   assign c_fields.comp_seen     = comp_seen_ff;
   assign c_fields.field_buffer  = field_buffer_ff;
   assign c_fields.pending_error = pending_error_ff;

   alw_c_encoder u_c_encoder (
      .fields (c_fields),
      .result (c_result)
   );

   // next parse state for the current character
   always_comb begin
      mode_in          = mode_ff;
      field_buffer_in  = field_buffer_ff;
      field_length_in  = field_length_ff;
      dest_bits_in     = dest_bits_ff;
      comp_text_in     = comp_text_ff;
      comp_seen_in     = comp_seen_ff;
      number_value_in  = number_value_ff;
      digit_count_in   = digit_count_ff;
      pending_error_in = pending_error_ff;
      line_counter_in  = line_counter_ff;
      cinst            = 1'b0;
      emit             = 1'b0;
      emit_word        = 16'h0000;
      emit_error       = ERR_NONE;

      unique case (mode_ff) inside
         MODE_SKIP, MODE_LABEL: begin
            // comment or label: wait for line end, or ')' inside a label
            if (line_end) begin
               mode_in = MODE_IDLE;
            end else if (mode_ff == MODE_LABEL && req_char_in == CH_RPAREN) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_ANUM: begin
            if (digit) begin
               if (digit_count_ff < DIGIT_W'(NUMBER_DIGITS)) begin
                  number_value_in = num_next_wide[NUM_W-1:0];
                  digit_count_in  = digit_count_ff + 1'b1;
               end else begin
                  // extra digits are dropped
                  pending_error_in = ERR_NUM;
               end
            end else begin
               // first non-digit ends the number, rest of the line is skipped
               emit       = 1'b1;
               emit_error = a_error;
               emit_word  = (a_error != ERR_NONE) ? 16'h0000
                          : {1'b0, number_value_ff[14:0]};
               mode_in    = line_end ? MODE_IDLE : MODE_SKIP;
            end
         end
         default: begin
            // idle, C-instruction and any stray code share this arm
            cinst = (mode_ff == MODE_CINST);
            if (!cinst) begin
               mode_in = MODE_IDLE;
               if (line_end || space || req_char_in == CH_RPAREN) begin
                  mode_in = MODE_IDLE;
               end else if (req_char_in == CH_SLASH) begin
                  mode_in = MODE_SKIP;
               end else if (req_char_in == CH_LPAREN) begin
                  mode_in = MODE_LABEL;
               end else begin
                  // any other character opens an instruction with clean fields
                  field_buffer_in  = '0;
                  field_length_in  = '0;
                  dest_bits_in     = '0;
                  comp_text_in     = '0;
                  comp_seen_in     = 1'b0;
                  number_value_in  = '0;
                  digit_count_in   = '0;
                  pending_error_in = ERR_NONE;
                  if (req_char_in == CH_AT) begin
                     mode_in = MODE_ANUM;
                  end else begin
                     mode_in = MODE_CINST;
                     cinst   = 1'b1;
                  end
               end
            end
            if (cinst) begin
               if (line_end || req_char_in == CH_SLASH) begin
                  // end of the C-instruction; a slash then opens a comment
                  emit       = 1'b1;
                  emit_word  = c_result.machine_word;
                  emit_error = c_result.error_code;
                  mode_in    = line_end ? MODE_IDLE : MODE_SKIP;
               end else if (req_char_in == CH_EQUAL) begin
                  dest_bits_in    = dest_from(field_buffer_in);
                  field_buffer_in = '0;
                  field_length_in = '0;
               end else if (req_char_in == CH_SEMI) begin
                  comp_text_in    = field_buffer_in;
                  comp_seen_in    = 1'b1;
                  field_buffer_in = '0;
                  field_length_in = '0;
               end else if (!space) begin
                  if (field_length_in < 2'(FIELD_CHARS)) begin
                     field_buffer_in = {field_buffer_in[FIELD_W-9:0], req_char_in};
                     field_length_in = field_length_in + 1'b1;
                  end else begin
                     // overlong field: character dropped
                     pending_error_in = ERR_LONG;
                  end
               end
            end
         end
      endcase

      // result carries the line number before the advance
      if (line_end) line_counter_in = line_counter_ff + 1'b1;
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_IDLE;
         field_buffer_ff  <= '0;
         field_length_ff  <= '0;
         dest_bits_ff     <= '0;
         comp_text_ff     <= '0;
         comp_seen_ff     <= 1'b0;
         number_value_ff  <= '0;
         digit_count_ff   <= '0;
         pending_error_ff <= ERR_NONE;
         line_counter_ff  <= 16'd1;
      end else if (accept) begin
         mode_ff          <= mode_in;
         field_buffer_ff  <= field_buffer_in;
         field_length_ff  <= field_length_in;
         dest_bits_ff     <= dest_bits_in;
         comp_text_ff     <= comp_text_in;
         comp_seen_ff     <= comp_seen_in;
         number_value_ff  <= number_value_in;
         digit_count_ff   <= digit_count_in;
         pending_error_ff <= pending_error_in;
         line_counter_ff  <= line_counter_in;
      end
   end

   // result register: filled by an emitting request, emptied when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_word_ff  <= emit_word;
         rsp_error_ff <= emit_error;
         rsp_line_ff  <= line_counter_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_machine_word = rsp_word_ff;
   assign rsp_error_code   = rsp_error_ff;
   assign rsp_line_number  = rsp_line_ff;

endmodule

`default_nettype wire

// ===== dv/machine_word_checker.sv =====
`timescale 1ns / 1ps

module machine_word_checker #(
   parameter int NUMBER_DIGITS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_machine_word,
   input  logic [2:0]  rsp_error_code,
   input  logic [15:0] rsp_line_number,
   output int          mismatch_count,
   output int          words_pending,
   output int          words_checked
);

   import alw_pkg::*;

   localparam logic [7:0] CH_NL = 8'h0A;

   typedef enum logic [2:0] {
      PM_IDLE,
      PM_SKIP,
      PM_LABEL,
      PM_ANUM,
      PM_CINST
   } parse_mode_type;

   typedef struct packed {
      logic [15:0] word;
      logic [2:0]  err;
      logic [15:0] line;
   } encoded_word_type;

   // mirror of the parser
   parse_mode_type     mode;
   logic [FIELD_W-1:0] field_buffer;
   int                 field_len;
   logic [2:0]         dest_bits;
   logic [FIELD_W-1:0] comp_text;
   logic               comp_seen;
   logic [NUM_W-1:0]   number_value;
   int                 digit_count;
   logic [2:0]         pending_error;
   logic [15:0]        line_count;

   encoded_word_type expected_words[$];
   encoded_word_type want;
   int               fails;
   int               checked;

   // {hit, c1..c6 with the a bit on top}
   function automatic logic [7:0] comp_encode(input logic [FIELD_W-1:0] txt);
      case (txt)
         "0":   return {1'b1, 7'h2A};
         "1":   return {1'b1, 7'h3F};
         "-1":  return {1'b1, 7'h3A};
         "D":   return {1'b1, 7'h0C};
         "A":   return {1'b1, 7'h30};
         "!D":  return {1'b1, 7'h0D};
         "!A":  return {1'b1, 7'h31};
         "-D":  return {1'b1, 7'h0F};
         "-A":  return {1'b1, 7'h33};
         "D+1": return {1'b1, 7'h1F};
         "A+1": return {1'b1, 7'h37};
         "D-1": return {1'b1, 7'h0E};
         "A-1": return {1'b1, 7'h32};
         "D+A": return {1'b1, 7'h02};
         "D-A": return {1'b1, 7'h13};
         "A-D": return {1'b1, 7'h07};
         "D&A": return {1'b1, 7'h00};
         "D|A": return {1'b1, 7'h15};
         "M":   return {1'b1, 7'h70};
         "!M":  return {1'b1, 7'h71};
         "-M":  return {1'b1, 7'h73};
         "M+1": return {1'b1, 7'h77};
         "M-1": return {1'b1, 7'h72};
         "D+M": return {1'b1, 7'h42};
         "D-M": return {1'b1, 7'h53};
         "M-D": return {1'b1, 7'h47};
         "D&M": return {1'b1, 7'h40};
         "D|M": return {1'b1, 7'h55};
         default: return 8'h00;
      endcase
   endfunction

   // {hit, j1..j3}
   function automatic logic [3:0] jump_encode(input logic [FIELD_W-1:0] txt);
      case (txt)
         "JGT": return {1'b1, 3'd1};
         "JEQ": return {1'b1, 3'd2};
         "JGE": return {1'b1, 3'd3};
         "JLT": return {1'b1, 3'd4};
         "JNE": return {1'b1, 3'd5};
         "JLE": return {1'b1, 3'd6};
         "JMP": return {1'b1, 3'd7};
         default: return 4'h0;
      endcase
   endfunction

   function automatic logic [2:0] dest_mask(input logic [FIELD_W-1:0] txt);
      logic [2:0] d;
      logic [7:0] ch;
      d = 3'b000;
      for (int i = 0; i < FIELD_CHARS; i++) begin
         ch = txt[8*i +: 8];
         if (ch == "A") d[2] = 1'b1;
         if (ch == "D") d[1] = 1'b1;
         if (ch == "M") d[0] = 1'b1;
      end
      return d;
   endfunction

   task automatic clear_fields();
      field_buffer  = '0;
      field_len     = 0;
      dest_bits     = 3'b000;
      comp_text     = '0;
      comp_seen     = 1'b0;
      number_value  = '0;
      digit_count   = 0;
      pending_error = ERR_NONE;
   endtask

   task automatic push_word(input logic [15:0] word, input logic [2:0] err);
      encoded_word_type w;
      w.word = (err != ERR_NONE) ? 16'h0000 : word;
      w.err  = err;
      w.line = line_count;
      expected_words.push_back(w);
   endtask

   task automatic finish_c_line();
      logic [7:0]         comp_hit;
      logic [3:0]         jump_hit;
      logic [2:0]         err;
      comp_hit = comp_encode(comp_seen ? comp_text : field_buffer);
      // no ';' means no jump at all, which is fine
      jump_hit = comp_seen ? jump_encode(field_buffer) : 4'b1000;
      err = pending_error;
      if (err == ERR_NONE && !comp_hit[7]) err = ERR_COMP;
      if (err == ERR_NONE && !jump_hit[3]) err = ERR_JUMP;
      push_word({3'b111, comp_hit[6:0], dest_bits, jump_hit[2:0]}, err);
   endtask

   task automatic predict_char(input logic [7:0] c, input logic eoi);
      logic       line_end;
      logic       blank;
      logic       digit;
      logic [2:0] err;
      line_end = eoi || (c == CH_NL);
      blank    = !eoi && (c == " " || c == 8'h00 || (c >= 8'd9 && c <= 8'd13));
      digit    = !eoi && c >= "0" && c <= "9";
      case (mode)
         PM_SKIP, PM_LABEL: begin
            if (line_end) mode = PM_IDLE;
            else if (mode == PM_LABEL && c == ")") mode = PM_IDLE;
         end
         PM_ANUM: begin
            if (digit) begin
               if (digit_count < NUMBER_DIGITS) begin
                  number_value = number_value * 17'd10 + {9'd0, c - 8'h30};
                  digit_count++;
               end else begin
                  pending_error = ERR_NUM;
               end
            end else begin
               err = pending_error;
               if (digit_count == 0 || number_value > MAX_A) err = ERR_NUM;
               push_word({1'b0, number_value[14:0]}, err);
               mode = line_end ? PM_IDLE : PM_SKIP;
            end
         end
         default: begin
            if (mode != PM_CINST) begin
               mode = PM_IDLE;
               if (line_end || blank || c == ")") begin
               end else if (c == "/") begin
                  mode = PM_SKIP;
               end else if (c == "(") begin
                  mode = PM_LABEL;
               end else if (c == "@") begin
                  clear_fields();
                  mode = PM_ANUM;
               end else begin
                  clear_fields();
                  mode = PM_CINST;
               end
            end
            if (mode == PM_CINST) begin
               if (line_end || c == "/") begin
                  finish_c_line();
                  mode = line_end ? PM_IDLE : PM_SKIP;
               end else if (c == "=") begin
                  dest_bits    = dest_mask(field_buffer);
                  field_buffer = '0;
                  field_len    = 0;
               end else if (c == ";") begin
                  comp_text    = field_buffer;
                  comp_seen    = 1'b1;
                  field_buffer = '0;
                  field_len    = 0;
               end else if (!blank) begin
                  if (field_len < FIELD_CHARS) begin
                     field_buffer = {field_buffer[FIELD_W-9:0], c};
                     field_len++;
                  end else begin
                     pending_error = ERR_LONG;
                  end
               end
            end
         end
      endcase
      if (line_end) line_count = line_count + 16'd1;
   endtask

   task automatic check_word();
      if (expected_words.size() == 0) begin
         $display("%0t unexpected result: expected none, got word %h err %0d line %0d",
                  $time, rsp_machine_word, rsp_error_code, rsp_line_number);
         fails++;
      end else begin
         want = expected_words.pop_front();
         checked++;
         if (rsp_machine_word !== want.word) begin
            $display("%0t machine_word mismatch (line %0d): expected %h, got %h",
                     $time, want.line, want.word, rsp_machine_word);
            fails++;
         end
         if (rsp_error_code !== want.err) begin
            $display("%0t error_code mismatch (line %0d): expected %0d, got %0d",
                     $time, want.line, want.err, rsp_error_code);
            fails++;
         end
         if (rsp_line_number !== want.line) begin
            $display("%0t line_number mismatch: expected %0d, got %0d",
                     $time, want.line, rsp_line_number);
            fails++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode       = PM_IDLE;
         clear_fields();
         line_count = 16'd1;
         expected_words.delete();
      end else begin
         if (req_valid && req_ready) predict_char(req_char_in, req_end_of_input);
         if (rsp_valid && rsp_ready) check_word();
      end
      mismatch_count <= fails;
      words_pending  <= expected_words.size();
      words_checked  <= checked;
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   // character codes used by the stimulus
   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_TAB = 8'h09;

   localparam int RANDOM_CHARS   = 490;   // random part of the source text
   localparam int HOLD_CYCLES    = 250;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
   localparam int DRAIN_CYCLES   = 8;     // settle time after the last result

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_char_in;
   logic        req_end_of_input;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_machine_word;
   logic [2:0]  rsp_error_code;
   logic [15:0] rsp_line_number;

   int mismatch_count;
   int words_pending;
   int words_checked;

   // stimulus bookkeeping
   int          send_idle_pct;
   int          rcv_idle_pct;
   int          chars_sent;
   int          lines_ended;
   int          hold_requests;
   int          hold_served;
   int          quiet_cycles;
   logic [7:0]  line_buf[$];    // one source line under construction

   asm_line_to_machine_word_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_machine_word (rsp_machine_word),
      .rsp_error_code   (rsp_error_code),
      .rsp_line_number  (rsp_line_number)
   );

   machine_word_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_machine_word (rsp_machine_word),
      .rsp_error_code   (rsp_error_code),
      .rsp_line_number  (rsp_line_number),
      .mismatch_count   (mismatch_count),
      .words_pending    (words_pending),
      .words_checked    (words_checked)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // mnemonic tables for building source text, right aligned, first char highest
   function automatic logic [23:0] comp_name(input int idx);
      case (idx)
         0:  return "0";    1:  return "1";    2:  return "-1";   3:  return "D";
         4:  return "A";    5:  return "!D";   6:  return "!A";   7:  return "-D";
         8:  return "-A";   9:  return "D+1";  10: return "A+1";  11: return "D-1";
         12: return "A-1";  13: return "D+A";  14: return "D-A";  15: return "A-D";
         16: return "D&A";  17: return "D|A";  18: return "M";    19: return "!M";
         20: return "-M";   21: return "M+1";  22: return "M-1";  23: return "D+M";
         24: return "D-M";  25: return "M-D";  26: return "D&M";  default: return "D|M";
      endcase
   endfunction

   function automatic logic [23:0] jump_name(input int idx);
      case (idx)
         0: return "JGT";  1: return "JEQ";  2: return "JGE";  3: return "JLT";
         4: return "JNE";  5: return "JLE";  default: return "JMP";
      endcase
   endfunction

   // characters that look like parts of a mnemonic, for broken fields
   function automatic logic [7:0] mnemonic_char();
      case ($urandom_range(0, 11))
         0: return "A";  1: return "D";  2: return "M";  3: return "0";
         4: return "1";  5: return "-";  6: return "+";  7: return "!";
         8: return "&";  9: return "|";  10: return "J";  default: return "=";
      endcase
   endfunction

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   // one request on the character channel; waits for the handshake
   task automatic send_char(input logic [7:0] c, input logic eoi);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_char_in      <= c;
      req_end_of_input <= eoi;
      do @(posedge clock); while (!(req_valid && req_ready));
      chars_sent++;
      if (eoi || c == CH_NL) lines_ended++;
   endtask

   task automatic send_stmt(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
      send_char(CH_NL, 1'b0);
   endtask

   // append a character, now and then with a blank in front
   task automatic put_char(input logic [7:0] c);
      if ($urandom_range(0, 9) == 0) line_buf.push_back($urandom_range(0, 1) ? " " : CH_TAB);
      line_buf.push_back(c);
   endtask

   task automatic put_text(input logic [23:0] t);
      for (int i = 2; i >= 0; i--)
         if (t[8*i +: 8] != 8'h00) put_char(t[8*i +: 8]);
   endtask

   task automatic put_number(input int unsigned v);
      logic [7:0]  digits[$];
      int unsigned rest;
      rest = v;
      do begin
         digits.push_front(8'(8'h30 + rest % 10));
         rest = rest / 10;
      end while (rest != 0);
      // a leading zero still counts as a digit
      if ($urandom_range(0, 7) == 0) line_buf.push_back("0");
      foreach (digits[i]) line_buf.push_back(digits[i]);
   endtask

   // dest=comp;jump with random parts left out or broken
   task automatic build_c_line();
      if ($urandom_range(0, 2) != 0) begin
         if ($urandom_range(0, 1)) put_char("A");
         if ($urandom_range(0, 1)) put_char("D");
         if ($urandom_range(0, 1)) put_char("M");
         if ($urandom_range(0, 15) == 0) put_char("X");
         put_char("=");
      end
      if ($urandom_range(0, 9) != 0) put_text(comp_name($urandom_range(0, 27)));
      else repeat ($urandom_range(0, 4)) put_char(mnemonic_char());
      if ($urandom_range(0, 1)) begin
         put_char(";");
         if ($urandom_range(0, 9) != 0) put_text(jump_name($urandom_range(0, 6)));
         else repeat ($urandom_range(0, 4)) put_char(mnemonic_char());
      end
      if ($urandom_range(0, 6) == 0) begin
         put_char("/");
         put_char("/");
         put_char("c");
      end
   endtask

   // @value, biased toward the 15-bit limit and the digit limit
   task automatic build_a_line();
      put_char("@");
      case ($urandom_range(0, 5))
         0: put_number($urandom_range(0, 32767));
         1: put_number($urandom_range(32760, 32775));
         2: put_number($urandom_range(0, 99999));
         3: put_number($urandom_range(0, 9));
         4: repeat ($urandom_range(6, 8)) line_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
         default: if ($urandom_range(0, 1)) line_buf.push_back("i");  // symbolic or empty
      endcase
      case ($urandom_range(0, 3))
         0: begin
            line_buf.push_back(" ");
            line_buf.push_back("x");
         end
         1: begin
            line_buf.push_back("/");
            line_buf.push_back("/");
         end
         2: line_buf.push_back("D");
         default: ;
      endcase
   endtask

   // labels, comments, blank lines and stray parentheses
   task automatic build_misc_line();
      case ($urandom_range(0, 3))
         0: begin
            put_char("(");
            repeat ($urandom_range(1, 5)) put_char(mnemonic_char());
            if ($urandom_range(0, 3) != 0) put_char(")");
            if ($urandom_range(0, 2) == 0) build_c_line();
         end
         1: begin
            put_char("/");
            repeat ($urandom_range(0, 5)) put_char(mnemonic_char());
         end
         2: repeat ($urandom_range(0, 3)) put_char(" ");
         default: begin
            put_char(")");
            build_c_line();
         end
      endcase
   endtask

   task automatic random_line();
      int pick;
      line_buf.delete();
      pick = $urandom_range(0, 99);
      if (pick < 45) build_c_line();
      else if (pick < 70) build_a_line();
      else if (pick < 85) build_misc_line();
      else repeat ($urandom_range(1, 6)) line_buf.push_back(rand_byte());
      foreach (line_buf[i]) send_char(line_buf[i], 1'b0);
      // end of input acts as a line end, whatever the character
      if ($urandom_range(0, 19) == 0) send_char(rand_byte(), 1'b1);
      else send_char(CH_NL, 1'b0);
   endtask

   // receiver: random ready, or a long hold-off when the stimulus asks for one
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served < hold_requests) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_served++;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no handshake for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, words_pending);
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      int directed_chars;
      int phase;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_char_in      = 8'h00;
      req_end_of_input = 1'b0;
      send_idle_pct    = 0;
      rcv_idle_pct     = 0;
      chars_sent       = 0;
      lines_ended      = 0;
      hold_requests    = 0;
      phase            = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // first profile: sender idles a little, receiver a lot
      send_idle_pct = 23;
      rcv_idle_pct  = 84;

      // directed: number limits, every kind of error, labels and comments
      send_stmt("@0");
      send_stmt("@32767");
      send_stmt("@32768");
      send_stmt("@99999");
      send_stmt("@123456");     // sixth digit dropped and flagged
      send_stmt("@x");          // symbolic address
      send_stmt("@");           // nothing after the at sign
      send_stmt("@5 x");        // number ends at the blank, rest skipped
      send_stmt("AMD=D|M;JMP");
      send_stmt("D=A-D");
      send_stmt("0;JGT");
      send_stmt("D+1;");        // empty jump field
      send_stmt("D;JXX");       // unknown jump
      send_stmt("M=X;JLE");     // unknown comp
      send_stmt("=;");          // comp missing
      send_stmt("ADMX=0");      // dest field too long
      send_stmt("A=1=D");       // second '=' overrides dest
      send_stmt("D;JEQ;JLT");   // second ';' overrides comp
      send_stmt(" \t D ; JNE");
      send_stmt("M=M+1//x");    // comment ends the instruction
      send_stmt("(LOOP)");
      send_stmt("(OPEN");       // label never closed
      send_stmt(")D=!M");       // stray close paren
      // NUL is a blank, 0xFF is not a mnemonic character
      send_char(8'h00, 1'b0);
      send_char("D", 1'b0);
      send_char("=", 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(CH_NL, 1'b0);
      // end of input in the middle of each instruction kind
      send_char("D", 1'b0);
      send_char("=", 1'b0);
      send_char("M", 1'b0);
      send_char(8'hA5, 1'b1);
      send_char("@", 1'b0);
      send_char("7", 1'b0);
      send_char(8'h5A, 1'b1);
      directed_chars = chars_sent;

      // random source text through the three idle profiles
      while (chars_sent < directed_chars + RANDOM_CHARS) begin
         if (phase == 0 && chars_sent >= directed_chars + RANDOM_CHARS / 3) begin
            phase = 1;
            send_idle_pct = 84;
            rcv_idle_pct  = 23;
         end else if (phase == 1 && chars_sent >= directed_chars + 2 * RANDOM_CHARS / 3) begin
            phase = 2;
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
            // receiver stalls while requests keep coming, so the core fills up
            hold_requests++;
         end
         random_line();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb_top: %0d characters over %0d source lines (%0d directed), %0d words checked",
               chars_sent, lines_ended, directed_chars, words_checked);
      $display("tb_top: idle mixes 23/84, 84/23 and none, plus a %0d-cycle receiver hold",
               HOLD_CYCLES);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
